// ----- hw/rtl/sals_pkg.sv -----
`timescale 1ns / 1ps

package sals_pkg;

  // Status codes as they appear on the result beat
  localparam logic [1:0] CODE_INVALID  = 2'd0;
  localparam logic [1:0] CODE_VALID    = 2'd1;
  localparam logic [1:0] CODE_ACCEPTED = 2'd2;
  localparam logic [1:0] CODE_RELEASE  = 2'd3;

  // Sign event codes
  localparam logic [1:0] EV_SETUP   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED     = 3'd4;

  // Register reset values
  localparam logic [15:0] SETUP_TICKS_RST   = 16'd10;
  localparam logic [15:0] CONFIRM_TICKS_RST = 16'd50;
  localparam logic [7:0]  MAX_SPEED_RST     = 8'd120;
  localparam logic [7:0]  MIN_SPEED_RST     = 8'd30;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_INVALID  = 4'b0001,
    ST_VALID    = 4'b0010,
    ST_ACCEPTED = 4'b0100,
    ST_RELEASE  = 4'b1000
  } status_t;

  typedef struct packed {
    logic        source_select;
    logic [15:0] setup_ticks;
    logic [15:0] confirm_ticks;
    logic [7:0]  max_speed;
    logic [7:0]  min_speed;
  } sals_cfg_t;

  typedef struct packed {
    logic       feature_enabled;
    logic       acc_active;
    logic       pilot_active;
    logic       sign_active;
    logic [1:0] sign_event;
    logic [7:0] sign_limit;
    logic       nav_valid;
    logic [7:0] nav_limit;
    logic [7:0] cruise_set_speed;
    logic       recommend_mode;
  } sals_in_t;

  typedef struct packed {
    status_t     status_now;
    logic [7:0]  speed_now;
    logic [7:0]  saved_set_speed;
    logic [7:0]  saved_assist_speed;
    logic [7:0]  prior_sign_limit;
    logic [7:0]  prior_nav_limit;
    status_t     status_last_tick;
    status_t     status_before_change;
    logic [15:0] setup_count;
    logic [15:0] release_count;
    logic [15:0] confirm_count;
  } sals_state_t;

  function automatic logic [1:0] status_code(input status_t st);
    logic [1:0] code;
    case (st)
      ST_VALID:    code = CODE_VALID;
      ST_ACCEPTED: code = CODE_ACCEPTED;
      ST_RELEASE:  code = CODE_RELEASE;
      default:     code = CODE_INVALID;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/speed_assist_limit_sequencer_unit.sv -----
`timescale 1ns / 1ps

// Speed assist limit sequencer: one input beat per control tick, one result
// beat back for each.
// Input stream (s_axis_*): the tick's enables, sign and map limits, the set
// speed and the recommend flag, packed in a 32-bit tdata.
// Result stream (m_axis_*): assist speed and status code in a 16-bit tdata.
// Configuration: cfg_wen / cfg_index / cfg_wdata write one register per
// cycle (0 source select, 1 setup ticks, 2 confirm ticks, 3 max, 4 min);
// write only while no beat is in flight.
// Each beat passes the input register, then the state update and the result
// register. Throughput is one beat per cycle while results are taken; the
// sequencer state is a single register rewritten as each beat leaves the
// input register, so the next beat sees the updated state.
// Reset (rst, synchronous) clears the sequencer state to invalid with zero
// speeds and counters and loads the register defaults.
// When the receiver stalls the result is held and the input register holds
// one more beat; s_axis_tready drops only when both are full.
module speed_assist_limit_sequencer_unit import sals_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [0] feature_enabled, [1] acc_active, [2] pilot_active, [3] sign_active,
  // [5:4] sign_event, [13:6] sign_limit, [14] nav_valid, [22:15] nav_limit,
  // [30:23] cruise_set_speed, [31] recommend_mode
  input  logic [31:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] assist_speed, [9:8] assist_status, [15:10] zero
  output logic [15:0]          m_axis_tdata,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  sals_cfg_t   cfg;
  sals_in_t    item;
  logic        item_valid;
  sals_state_t st;
  sals_state_t st_next;
  logic        advance;
  logic [7:0]  out_speed;
  logic [1:0]  out_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_select <= 1'b0;
      cfg.setup_ticks   <= SETUP_TICKS_RST;
      cfg.confirm_ticks <= CONFIRM_TICKS_RST;
      cfg.max_speed     <= MAX_SPEED_RST;
      cfg.min_speed     <= MIN_SPEED_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SOURCE_SELECT: cfg.source_select <= cfg_wdata[0];
        REG_SETUP_TICKS:   cfg.setup_ticks   <= cfg_wdata;
        REG_CONFIRM_TICKS: cfg.confirm_ticks <= cfg_wdata;
        REG_MAX_SPEED:     cfg.max_speed     <= cfg_wdata[7:0];
        REG_MIN_SPEED:     cfg.min_speed     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign advance       = item_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item.feature_enabled  <= s_axis_tdata[0];
      item.acc_active       <= s_axis_tdata[1];
      item.pilot_active     <= s_axis_tdata[2];
      item.sign_active      <= s_axis_tdata[3];
      item.sign_event       <= s_axis_tdata[5:4];
      item.sign_limit       <= s_axis_tdata[13:6];
      item.nav_valid        <= s_axis_tdata[14];
      item.nav_limit        <= s_axis_tdata[22:15];
      item.cruise_set_speed <= s_axis_tdata[30:23];
      item.recommend_mode   <= s_axis_tdata[31];
    end
  end

  sals_core u_core (
    .cfg     (cfg),
    .item    (item),
    .st      (st),
    .st_next (st_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.status_now           <= ST_INVALID;
      st.speed_now            <= 8'd0;
      st.saved_set_speed      <= 8'd0;
      st.saved_assist_speed   <= 8'd0;
      st.prior_sign_limit     <= 8'd0;
      st.prior_nav_limit      <= 8'd0;
      st.status_last_tick     <= ST_INVALID;
      st.status_before_change <= ST_INVALID;
      st.setup_count          <= 16'd0;
      st.release_count        <= 16'd0;
      st.confirm_count        <= 16'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_speed  <= st_next.speed_now;
      out_status <= status_code(st_next.status_now);
    end
  end

  assign m_axis_tdata = {6'd0, out_status, out_speed};

`ifndef NO_ASSERTIONS
  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // every state update produces a result beat
  a_update_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("state update without result beat");

  // a disengaged function always lands in invalid with zero speed and the setup and release counters cleared
  a_disengaged_invalid: assert property (@(posedge clk) disable iff (rst)
    (advance && (!item.feature_enabled || !item.acc_active || item.pilot_active)) |=>
      (st.status_now == ST_INVALID && st.setup_count == 16'd0 &&
       st.release_count == 16'd0 && st.speed_now == 8'd0))
    else $error("disengaged tick left state active");

  // valid or release results respect the clamp range when it is well formed
  a_clamped_speed: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_status == CODE_VALID || out_status == CODE_RELEASE) &&
     cfg.min_speed <= cfg.max_speed) |->
      (out_speed <= cfg.max_speed && out_speed >= cfg.min_speed))
    else $error("assist speed outside clamp range");
`endif

endmodule

// ----- hw/rtl/sals_core.sv -----
`timescale 1ns / 1ps

module sals_core import sals_pkg::*; (
  input  sals_cfg_t   cfg,
  input  sals_in_t    item,
  input  sals_state_t st,
  output sals_state_t st_next
);

  sals_state_t nx;

  always_comb begin
    nx = st;
    if (item.acc_active && !item.pilot_active && item.feature_enabled) begin
      if (!cfg.source_select) begin
        if (item.sign_active) begin
          case (item.sign_event)
            EV_SETUP: begin
              if (item.sign_limit != 8'd0 && st.prior_sign_limit == item.sign_limit) begin
                if (nx.setup_count != CNT_MAX) nx.setup_count = nx.setup_count + 16'd1;
              end else begin
                nx.setup_count = 16'd0;
              end
            end
            EV_RELEASE: begin
              if (item.sign_limit != 8'd0 && item.sign_limit == st.speed_now &&
                  st.prior_sign_limit == item.sign_limit) begin
                if (nx.release_count != CNT_MAX) nx.release_count = nx.release_count + 16'd1;
              end else begin
                nx.release_count = 16'd0;
              end
            end
            default: begin
              nx.setup_count   = 16'd0;
              nx.release_count = 16'd0;
            end
          endcase

          case (nx.status_now)
            ST_INVALID: begin
              nx.confirm_count      = 16'd0;
              nx.speed_now          = 8'd0;
              nx.saved_set_speed    = 8'd0;
              nx.saved_assist_speed = 8'd0;
              if (nx.setup_count == cfg.setup_ticks &&
                  item.sign_limit < item.cruise_set_speed) begin
                nx.status_now      = ST_VALID;
                nx.speed_now       = item.sign_limit;
                nx.saved_set_speed = item.cruise_set_speed;
              end
            end
            ST_VALID: begin
              if (item.recommend_mode && item.cruise_set_speed == nx.speed_now)
                nx.status_now = ST_ACCEPTED;
              if (nx.confirm_count < cfg.confirm_ticks) begin
                nx.confirm_count = nx.confirm_count + 16'd1;
              end else if (nx.status_before_change == ST_INVALID) begin
                nx.status_now = ST_INVALID;
              end else if (nx.status_before_change == ST_ACCEPTED) begin
                nx.status_now = ST_ACCEPTED;
                nx.speed_now  = nx.saved_assist_speed;
              end
            end
            ST_ACCEPTED: begin
              nx.confirm_count = 16'd0;
              if (item.cruise_set_speed != nx.speed_now) begin
                nx.status_now = ST_INVALID;
              end else if (nx.setup_count == cfg.setup_ticks) begin
                if (item.sign_limit < nx.saved_set_speed) begin
                  nx.status_now         = ST_VALID;
                  nx.saved_assist_speed = nx.speed_now;
                  nx.speed_now          = item.sign_limit;
                end else begin
                  nx.status_now = ST_RELEASE;
                end
              end
              if (nx.release_count == cfg.setup_ticks) nx.status_now = ST_RELEASE;
            end
            default: begin
              nx.speed_now = nx.saved_set_speed;
              if (item.recommend_mode && item.cruise_set_speed == nx.speed_now)
                nx.status_now = ST_INVALID;
              if (nx.confirm_count < cfg.confirm_ticks)
                nx.confirm_count = nx.confirm_count + 16'd1;
              else
                nx.status_now = ST_INVALID;
            end
          endcase

          // remember the state we came from on every change
          if (nx.status_last_tick != nx.status_now)
            nx.status_before_change = nx.status_last_tick;
          nx.status_last_tick = nx.status_now;
        end else begin
          nx.setup_count   = 16'd0;
          nx.release_count = 16'd0;
          nx.status_now    = ST_INVALID;
        end
      end else begin
        // map limit is reported only on the tick it changes
        if (item.nav_valid && st.prior_nav_limit != item.nav_limit) begin
          nx.speed_now  = item.nav_limit;
          nx.status_now = ST_VALID;
        end else begin
          nx.status_now = ST_INVALID;
        end
      end
    end else begin
      nx.status_now         = ST_INVALID;
      nx.speed_now          = 8'd0;
      nx.saved_set_speed    = 8'd0;
      nx.saved_assist_speed = 8'd0;
      nx.setup_count        = 16'd0;
      nx.release_count      = 16'd0;
    end

    // with an inverted clamp range, a speed above max goes to max and any other to min
    if (nx.status_now == ST_VALID || nx.status_now == ST_RELEASE) begin
      if (nx.speed_now > cfg.max_speed)
        nx.speed_now = cfg.max_speed;
      else if (nx.speed_now < cfg.min_speed)
        nx.speed_now = cfg.min_speed;
    end

    nx.prior_sign_limit = item.sign_limit;
    nx.prior_nav_limit  = item.nav_limit;
  end

  assign st_next = nx;

endmodule

// ----- sim/assist_speed_check.sv -----
`timescale 1ns / 1ps

module assist_speed_check
  import sals_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [15:0]          m_axis_tdata,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  output int unsigned          ticks_due,
  output int unsigned          mismatches
);

  typedef struct packed {
    logic [7:0] speed;
    logic [1:0] status;
  } assist_out_t;

  assist_out_t assist_due[$];

  logic        src_nav;
  logic [15:0] setup_lim;
  logic [15:0] confirm_lim;
  logic [7:0]  max_spd;
  logic [7:0]  min_spd;

  logic [1:0]  st_now;
  logic [1:0]  st_last;
  logic [1:0]  st_before;
  logic [7:0]  spd;
  logic [7:0]  saved_set;
  logic [7:0]  saved_assist;
  logic [7:0]  prev_sign;
  logic [7:0]  prev_nav;
  logic [15:0] setup_cnt;
  logic [15:0] release_cnt;
  logic [15:0] confirm_cnt;

  function automatic void sign_states(input logic [7:0] lim, input logic [7:0] setspd,
                                      input logic rec);
    case (st_now)
      CODE_INVALID: begin
        confirm_cnt = '0;
        spd = '0;
        saved_set = '0;
        saved_assist = '0;
        if (setup_cnt == setup_lim && lim < setspd) begin
          st_now = CODE_VALID;
          spd = lim;
          saved_set = setspd;
        end
      end
      CODE_VALID: begin
        if (rec && setspd == spd) st_now = CODE_ACCEPTED;
        // a timeout overrides an acceptance in the same tick when the state before the change was invalid or accepted
        if (confirm_cnt < confirm_lim) begin
          confirm_cnt = confirm_cnt + 16'd1;
        end else if (st_before == CODE_INVALID) begin
          st_now = CODE_INVALID;
        end else if (st_before == CODE_ACCEPTED) begin
          st_now = CODE_ACCEPTED;
          spd = saved_assist;
        end
      end
      CODE_ACCEPTED: begin
        confirm_cnt = '0;
        if (setspd != spd) begin
          st_now = CODE_INVALID;
        end else if (setup_cnt == setup_lim) begin
          if (lim < saved_set) begin
            st_now = CODE_VALID;
            saved_assist = spd;
            spd = lim;
          end else begin
            st_now = CODE_RELEASE;
          end
        end
        if (release_cnt == setup_lim) st_now = CODE_RELEASE;
      end
      default: begin
        spd = saved_set;
        if (rec && setspd == spd) st_now = CODE_INVALID;
        if (confirm_cnt < confirm_lim) confirm_cnt = confirm_cnt + 16'd1;
        else st_now = CODE_INVALID;
      end
    endcase
  endfunction

  function automatic assist_out_t step_sequencer(input logic [31:0] word);
    logic        en;
    logic        acc;
    logic        pilot;
    logic        sact;
    logic [1:0]  ev;
    logic [7:0]  slim;
    logic        nvalid;
    logic [7:0]  nlim;
    logic [7:0]  setspd;
    logic        rec;
    assist_out_t res;
    en     = word[0];
    acc    = word[1];
    pilot  = word[2];
    sact   = word[3];
    ev     = word[5:4];
    slim   = word[13:6];
    nvalid = word[14];
    nlim   = word[22:15];
    setspd = word[30:23];
    rec    = word[31];
    if (acc && !pilot && en) begin
      if (!src_nav) begin
        if (sact) begin
          if (ev == EV_SETUP) begin
            if (slim != 8'd0 && prev_sign == slim) begin
              if (setup_cnt != CNT_MAX) setup_cnt = setup_cnt + 16'd1;
            end else begin
              setup_cnt = '0;
            end
          end else if (ev == EV_RELEASE) begin
            if (slim != 8'd0 && slim == spd && prev_sign == slim) begin
              if (release_cnt != CNT_MAX) release_cnt = release_cnt + 16'd1;
            end else begin
              release_cnt = '0;
            end
          end else begin
            setup_cnt = '0;
            release_cnt = '0;
          end
          sign_states(slim, setspd, rec);
          if (st_last != st_now) st_before = st_last;
          st_last = st_now;
        end else begin
          // history is left alone when the sign output drops
          setup_cnt = '0;
          release_cnt = '0;
          st_now = CODE_INVALID;
        end
      end else begin
        if (nvalid && prev_nav != nlim) begin
          spd = nlim;
          st_now = CODE_VALID;
        end else begin
          st_now = CODE_INVALID;
        end
      end
    end else begin
      st_now = CODE_INVALID;
      spd = '0;
      saved_set = '0;
      saved_assist = '0;
      setup_cnt = '0;
      release_cnt = '0;
    end
    if (st_now == CODE_VALID || st_now == CODE_RELEASE) begin
      if (spd > max_spd) spd = max_spd;
      else if (spd < min_spd) spd = min_spd;
    end
    prev_sign = slim;
    prev_nav = nlim;
    res.speed = spd;
    res.status = st_now;
    return res;
  endfunction

  always @(posedge clk) begin
    assist_out_t got;
    assist_out_t want;
    int unsigned errs;
    errs = 0;
    if (rst) begin
      src_nav = 1'b0;
      setup_lim = SETUP_TICKS_RST;
      confirm_lim = CONFIRM_TICKS_RST;
      max_spd = MAX_SPEED_RST;
      min_spd = MIN_SPEED_RST;
      st_now = CODE_INVALID;
      st_last = CODE_INVALID;
      st_before = CODE_INVALID;
      spd = '0;
      saved_set = '0;
      saved_assist = '0;
      prev_sign = '0;
      prev_nav = '0;
      setup_cnt = '0;
      release_cnt = '0;
      confirm_cnt = '0;
      assist_due.delete();
      ticks_due <= 0;
      mismatches <= 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_SOURCE_SELECT: src_nav = cfg_wdata[0];
          REG_SETUP_TICKS:   setup_lim = cfg_wdata;
          REG_CONFIRM_TICKS: confirm_lim = cfg_wdata;
          REG_MAX_SPEED:     max_spd = cfg_wdata[7:0];
          REG_MIN_SPEED:     min_spd = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = step_sequencer(s_axis_tdata);
        assist_due.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.speed = m_axis_tdata[7:0];
        got.status = m_axis_tdata[9:8];
        if (assist_due.size() == 0) begin
          $display("%0t result beat with none due: speed %0d status %0d",
                   $time, got.speed, got.status);
          errs++;
        end else begin
          want = assist_due.pop_front();
          if (got.speed !== want.speed) begin
            $display("%0t assist_speed: expected %0d, got %0d", $time, want.speed, got.speed);
            errs++;
          end
          if (got.status !== want.status) begin
            $display("%0t assist_status: expected %0d, got %0d",
                     $time, want.status, got.status);
            errs++;
          end
        end
      end
      ticks_due <= assist_due.size();
      mismatches <= mismatches + errs;
    end
  end

endmodule

// ----- sim/speed_assist_limit_sequencer_unit_test.sv -----
`timescale 1ns / 1ps

module speed_assist_limit_sequencer_unit_test;
  import sals_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam logic [1:0]  EV_NONE  = 2'd0;
  localparam logic [1:0]  EV_SPARE = 2'd3;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_wdata = '0;

  int unsigned ticks_due;
  int unsigned mismatches;
  int unsigned quiet_cycles = 0;
  int unsigned rx_hold = 0;
  int unsigned items_sent = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  logic        cur_src;
  logic [15:0] cur_setup;
  logic [15:0] cur_confirm;
  logic [7:0]  cur_max;
  logic [7:0]  cur_min;

  speed_assist_limit_sequencer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  assist_speed_check assist_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .ticks_due     (ticks_due),
    .mismatches    (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL speed_assist_limit_sequencer_unit");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // hold the result side low for a random stretch now and then
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) rx_hold = idle_len();
    end
  end

  function automatic logic [31:0] tick_word(input logic en, input logic acc,
                                            input logic pilot, input logic sact,
                                            input logic [1:0] ev, input logic [7:0] slim,
                                            input logic nvalid, input logic [7:0] nlim,
                                            input logic [7:0] setspd, input logic rec);
    return {rec, setspd, nlim, nvalid, slim, ev, sact, pilot, acc, en};
  endfunction

  // engaged sign tick, now and then with one enable flipped
  function automatic logic [31:0] engaged_tick(input logic [1:0] ev, input logic [7:0] slim,
                                               input logic [7:0] setspd, input logic rec);
    logic [31:0] w;
    logic [4:0]  pos;
    w = tick_word(1'b1, 1'b1, 1'b0, 1'b1, ev, slim, 1'($urandom_range(0, 1)),
                  8'($urandom()), setspd, rec);
    if ($urandom_range(0, 49) == 0) begin
      pos = 5'($urandom_range(0, 3));
      w[pos] = ~w[pos];
    end
    return w;
  endfunction

  function automatic logic [7:0] pick_limit();
    int unsigned lo;
    int unsigned hi;
    lo = (cur_min == 8'd0) ? 1 : cur_min;
    hi = (cur_max > 8'd200) ? 200 : cur_max;
    if (lo > hi) return 8'($urandom_range(1, 200));
    return 8'($urandom_range(lo, hi));
  endfunction

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (ticks_due != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic push_tick(input logic [31:0] word);
    if (!tx_steady && $urandom_range(0, 199) == 0) begin
      drain();
    end else if (!tx_steady && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat (idle_len()) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = word;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic apply_setting(input logic src, input logic [15:0] setup,
                               input logic [15:0] confirm, input logic [7:0] mx,
                               input logic [7:0] mn);
    drain();
    write_reg(REG_SOURCE_SELECT, {15'd0, src});
    write_reg(REG_SETUP_TICKS, setup);
    write_reg(REG_CONFIRM_TICKS, confirm);
    write_reg(REG_MAX_SPEED, {8'd0, mx});
    write_reg(REG_MIN_SPEED, {8'd0, mn});
    cur_src = src;
    cur_setup = setup;
    cur_confirm = confirm;
    cur_max = mx;
    cur_min = mn;
  endtask

  // persist a sign until valid, accept it or let it time out, then lower, release or drop out
  task automatic run_episode();
    logic [7:0]  lim;
    logic [7:0]  lim2;
    logic [7:0]  high_set;
    int unsigned hold;
    int unsigned wait_t;
    lim = pick_limit();
    high_set = lim + 8'($urandom_range(1, 55));
    hold = cur_setup + 1;
    wait_t = (cur_confirm > 16'd20) ? 20 : cur_confirm;
    repeat (hold + $urandom_range(0, 3))
      push_tick(engaged_tick(EV_SETUP, lim, high_set, 1'b0));
    if ($urandom_range(0, 3) != 0)
      push_tick(engaged_tick(EV_SETUP, lim, lim, 1'b1));
    else
      repeat (wait_t + 2)
        push_tick(engaged_tick(EV_SETUP, lim, high_set, 1'($urandom_range(0, 1))));
    repeat ($urandom_range(1, 4))
      push_tick(engaged_tick(EV_SETUP, lim, lim, 1'($urandom_range(0, 1))));
    case ($urandom_range(0, 3))
      0: begin
        lim2 = (lim > 8'd2) ? lim - 8'($urandom_range(1, lim - 1)) : lim;
        repeat (hold + $urandom_range(0, 2))
          push_tick(engaged_tick(EV_SETUP, lim2, lim, 1'b0));
        repeat (wait_t + 2)
          push_tick(engaged_tick(EV_SETUP, lim2, $urandom_range(0, 1) ? lim2 : lim,
                                 $urandom_range(0, 3) == 0));
      end
      1: begin
        repeat (hold + $urandom_range(0, 2))
          push_tick(engaged_tick(EV_RELEASE, lim, lim, 1'b0));
        repeat ($urandom_range(1, wait_t + 2))
          push_tick(engaged_tick(EV_NONE, lim, high_set, $urandom_range(0, 3) == 0));
      end
      2: begin
        push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b0, EV_SETUP, lim, 1'b0, 8'd0, lim, 1'b0));
        push_tick(engaged_tick(EV_SETUP, lim, high_set, 1'b0));
      end
      default: begin
        push_tick(tick_word(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)), 1'b1,
                            EV_SETUP, lim, 1'b0, 8'd0, lim, 1'b0));
      end
    endcase
  endtask

  task automatic nav_burst();
    logic [7:0] nlim;
    nlim = 8'($urandom());
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 2) == 0) nlim = 8'($urandom());
      push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1)),
                          2'($urandom_range(0, 3)), 8'($urandom()),
                          $urandom_range(0, 3) != 0, nlim, 8'($urandom()),
                          1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned stop;
    stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(0, 15) == 0) tx_steady = ~tx_steady;
      if ($urandom_range(0, 15) == 0) rx_steady = ~rx_steady;
      if ($urandom_range(0, 4) == 0) push_tick($urandom());
      else if (cur_src) nav_burst();
      else run_episode();
    end
  endtask

  initial begin
    cur_src = 1'b0;
    cur_setup = SETUP_TICKS_RST;
    cur_confirm = CONFIRM_TICKS_RST;
    cur_max = MAX_SPEED_RST;
    cur_min = MIN_SPEED_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: sign path through every state, then the map source
    apply_setting(1'b0, 16'd1, 16'd2, 8'd120, 8'd30);
    push_tick(tick_word(1'b0, 1'b0, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    push_tick(tick_word(1'b1, 1'b1, 1'b1, 1'b1, EV_SPARE, 8'd255, 1'b1, 8'd255, 8'd255,
                        1'b1));
    repeat (2)
      push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1, EV_SETUP, 8'd80, 1'b0, 8'd0, 8'd100, 1'b0));
    push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1, EV_SETUP, 8'd80, 1'b0, 8'd0, 8'd80, 1'b1));
    repeat (2)
      push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1, EV_SETUP, 8'd60, 1'b0, 8'd0, 8'd80, 1'b0));
    repeat (3)
      push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1, EV_SETUP, 8'd60, 1'b0, 8'd0, 8'd80, 1'b0));
    repeat (2)
      push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1, EV_RELEASE, 8'd80, 1'b0, 8'd0, 8'd80,
                          1'b0));
    push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b0, EV_SETUP, 8'd50, 1'b0, 8'd0, 8'd90, 1'b0));
    repeat (2)
      push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1, EV_SETUP, 8'd50, 1'b0, 8'd0, 8'd90, 1'b0));
    repeat (3)
      push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1, EV_SETUP, 8'd50, 1'b0, 8'd0, 8'd90, 1'b0));
    push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1, EV_SPARE, 8'd50, 1'b0, 8'd0, 8'd90, 1'b0));
    push_tick(tick_word(1'b0, 1'b1, 1'b0, 1'b1, EV_SETUP, 8'd50, 1'b0, 8'd0, 8'd90, 1'b0));
    push_tick(tick_word(1'b1, 1'b0, 1'b0, 1'b1, EV_SETUP, 8'd50, 1'b0, 8'd0, 8'd90, 1'b0));
    push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b1, EV_SETUP, 8'd255, 1'b1, 8'd255, 8'd255,
                        1'b1));
    apply_setting(1'b1, 16'd1, 16'd2, 8'd40, 8'd200);
    push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b1, 8'd0, 8'd0, 1'b0));
    push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b1, 8'd255, 8'd0, 1'b0));
    push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b1, 8'd255, 8'd0, 1'b0));
    push_tick(tick_word(1'b1, 1'b1, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0, 8'd100, 8'd0, 1'b0));

    // random phases over several register settings
    apply_setting(1'b0, SETUP_TICKS_RST, CONFIRM_TICKS_RST, MAX_SPEED_RST, MIN_SPEED_RST);
    run_phase(300);
    apply_setting(1'b0, 16'd2, 16'd4, 8'd255, 8'd0);
    run_phase(350);
    apply_setting(1'b0, 16'd0, 16'd0, 8'd0, 8'd0);
    run_phase(150);
    apply_setting(1'b0, 16'd3, 16'hFFFF, 8'd200, 8'd250);
    run_phase(200);
    apply_setting(1'b1, 16'd3, 16'd5, 8'd255, 8'd0);
    run_phase(150);
    apply_setting(1'b1, 16'd3, 16'd5, 8'd90, 8'd40);
    run_phase(100);

    apply_setting(1'b0, 16'd5, 16'd10, 8'd255, 8'd1);
    run_phase(150);

    s_axis_tvalid = 1'b0;
    while (ticks_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("PASS speed_assist_limit_sequencer_unit");
    else
      $display("FAIL speed_assist_limit_sequencer_unit");
    $finish;
  end

endmodule
